>>> rtl/core/fkn_pkg.sv
package fkn_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VLAN_AGN   = 2'd0,
    CFG_ASPACE_AGN = 2'd1,
    CFG_MPLS_AGN   = 2'd2
  } cfg_idx_e;

  localparam logic [15:0] GroupUnknown   = 16'hFFFF;
  localparam logic [7:0]  ProtoIcmp4     = 8'd1;
  localparam logic [7:0]  ProtoIcmp6     = 8'd58;
  localparam logic [63:0] MappedZeroLow  = 64'h0000_FFFF_0000_0000;

  localparam logic [15:0] Icmp4EchoRep   = 16'd0;
  localparam logic [15:0] Icmp4EchoReq   = 16'd8;
  localparam logic [15:0] Icmp4RtrAdv    = 16'd9;
  localparam logic [15:0] Icmp4RtrSol    = 16'd10;
  localparam logic [15:0] Icmp6EchoRep   = 16'd129;
  localparam logic [15:0] Icmp6EchoReq   = 16'd128;
  localparam logic [15:0] Icmp6RtrAdv    = 16'd134;
  localparam logic [15:0] Icmp6RtrSol    = 16'd133;

  typedef struct packed {
    logic vlan;
    logic aspace;
    logic mpls;
  } agn_cfg_t;

  typedef struct packed {
    logic        frag;
    logic        v4;
    logic [63:0] su;
    logic [63:0] sl;
    logic [63:0] du;
    logic [63:0] dl;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  proto;
    logic [7:0]  ptype;
    logic [11:0] vlan;
    logic [19:0] mpls;
    logic [31:0] aspace;
    logic [15:0] grp_ing;
    logic [15:0] grp_egr;
  } flow_t;

  typedef struct packed {
    flow_t flow;
    logic  lt;
    logic  eq;
    logic  port_lt;
  } cmp_t;

  typedef struct packed {
    logic [63:0] low_addr_upper;
    logic [63:0] low_addr_lower;
    logic [63:0] high_addr_upper;
    logic [63:0] high_addr_lower;
    logic [31:0] key_ports;
    logic [31:0] key_groups;
    logic [11:0] key_vlan;
    logic [19:0] key_mpls;
    logic [31:0] key_addr_space;
    logic [16:0] key_meta;
    logic        swapped;
  } key_t;

endpackage

>>> rtl/core/fkn_if.sv
interface fkn_flow_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        both_ipv4;
  logic [63:0] src_addr_upper;
  logic [63:0] src_addr_lower;
  logic [63:0] dst_addr_upper;
  logic [63:0] dst_addr_lower;
  logic [31:0] ports_or_id;
  logic [15:0] proto_and_type;
  logic [11:0] vlan_id;
  logic [19:0] mpls_in;
  logic [31:0] addr_space_in;
  logic [31:0] groups_in;

  modport source (
    output valid, kind, both_ipv4, src_addr_upper, src_addr_lower, dst_addr_upper,
           dst_addr_lower, ports_or_id, proto_and_type, vlan_id, mpls_in,
           addr_space_in, groups_in,
    input  ready
  );
  modport sink (
    input  valid, kind, both_ipv4, src_addr_upper, src_addr_lower, dst_addr_upper,
           dst_addr_lower, ports_or_id, proto_and_type, vlan_id, mpls_in,
           addr_space_in, groups_in,
    output ready
  );
endinterface

interface fkn_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] low_addr_upper;
  logic [63:0] low_addr_lower;
  logic [63:0] high_addr_upper;
  logic [63:0] high_addr_lower;
  logic [31:0] key_ports;
  logic [31:0] key_groups;
  logic [11:0] key_vlan;
  logic [19:0] key_mpls;
  logic [31:0] key_addr_space;
  logic [16:0] key_meta;
  logic        swapped;

  modport source (
    output valid, low_addr_upper, low_addr_lower, high_addr_upper, high_addr_lower,
           key_ports, key_groups, key_vlan, key_mpls, key_addr_space, key_meta,
           swapped,
    input  ready
  );
  modport sink (
    input  valid, low_addr_upper, low_addr_lower, high_addr_upper, high_addr_lower,
           key_ports, key_groups, key_vlan, key_mpls, key_addr_space, key_meta,
           swapped,
    output ready
  );
endinterface

>>> rtl/core/fkn_icmp.sv
module fkn_icmp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  fkn_pkg::flow_t flow_i,
  output logic          valid_o,
  input  logic          ready_i,
  output fkn_pkg::flow_t flow_o
);

  logic           valid_q;
  fkn_pkg::flow_t flow_d, flow_q;
  logic           icmp6, icmp4;
  logic [15:0]    t_rep, t_req, t_adv, t_sol;
  logic [63:0]    zero_lower;

  always_comb begin
    icmp6      = (flow_i.proto == fkn_pkg::ProtoIcmp6) && !flow_i.v4;
    icmp4      = (flow_i.proto == fkn_pkg::ProtoIcmp4);
    t_rep      = icmp6 ? fkn_pkg::Icmp6EchoRep : fkn_pkg::Icmp4EchoRep;
    t_req      = icmp6 ? fkn_pkg::Icmp6EchoReq : fkn_pkg::Icmp4EchoReq;
    t_adv      = icmp6 ? fkn_pkg::Icmp6RtrAdv  : fkn_pkg::Icmp4RtrAdv;
    t_sol      = icmp6 ? fkn_pkg::Icmp6RtrSol  : fkn_pkg::Icmp4RtrSol;
    zero_lower = icmp6 ? 64'd0 : fkn_pkg::MappedZeroLow;
    flow_d     = flow_i;
    if (icmp6 || icmp4) begin
      if (flow_i.sp == t_rep) begin
        flow_d.dp = t_req;
        flow_d.sp = 16'd0;
      end else if (flow_i.sp == t_adv) begin
        flow_d.dp = t_sol;
        flow_d.sp = 16'd0;
        flow_d.su = 64'd0;
        flow_d.sl = zero_lower;
      end else begin
        flow_d.dp = 16'd0;
        if (flow_i.sp == t_sol) begin
          flow_d.du = 64'd0;
          flow_d.dl = zero_lower;
        end
      end
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign flow_o  = flow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      flow_q <= flow_d;
    end
  end

endmodule

>>> rtl/core/fkn_cmp.sv
module fkn_cmp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  fkn_pkg::flow_t flow_i,
  output logic           valid_o,
  input  logic           ready_i,
  output fkn_pkg::cmp_t  cmp_o
);

  logic          valid_q;
  fkn_pkg::cmp_t cmp_d, cmp_q;

  always_comb begin
    cmp_d.flow    = flow_i;
    cmp_d.port_lt = flow_i.sp < flow_i.dp;
    if (flow_i.v4) begin
      cmp_d.lt = flow_i.sl[31:0] < flow_i.dl[31:0];
      cmp_d.eq = flow_i.sl[31:0] == flow_i.dl[31:0];
    end else begin
      cmp_d.lt = {flow_i.su, flow_i.sl} < {flow_i.du, flow_i.dl};
      cmp_d.eq = {flow_i.su, flow_i.sl} == {flow_i.du, flow_i.dl};
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign cmp_o   = cmp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      cmp_q <= cmp_d;
    end
  end

  a_lt_eq_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !(cmp_q.lt && cmp_q.eq))
    else $error("address compare both below and equal");

endmodule

>>> rtl/core/fkn_order.sv
module fkn_order (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fkn_pkg::agn_cfg_t cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  fkn_pkg::cmp_t     cmp_i,
  output logic              valid_o,
  input  logic              ready_i,
  output fkn_pkg::key_t     key_o
);

  logic          valid_q;
  fkn_pkg::key_t key_d, key_q;
  fkn_pkg::flow_t f;
  logic          addr_swap, rev, grp_known;

  always_comb begin
    f         = cmp_i.flow;
    addr_swap = !f.frag && !cmp_i.lt && !cmp_i.eq;
    rev       = !f.frag && !cmp_i.lt && (!cmp_i.eq || !cmp_i.port_lt);
    grp_known = (f.grp_ing != fkn_pkg::GroupUnknown) &&
                (f.grp_egr != fkn_pkg::GroupUnknown);

    key_d.low_addr_upper  = addr_swap ? f.du : f.su;
    key_d.low_addr_lower  = addr_swap ? f.dl : f.sl;
    key_d.high_addr_upper = addr_swap ? f.su : f.du;
    key_d.high_addr_lower = addr_swap ? f.sl : f.dl;
    key_d.key_ports       = rev ? {f.sp, f.dp} : {f.dp, f.sp};
    if (!grp_known) begin
      key_d.key_groups = {fkn_pkg::GroupUnknown, fkn_pkg::GroupUnknown};
    end else if (rev) begin
      key_d.key_groups = {f.grp_ing, f.grp_egr};
    end else begin
      key_d.key_groups = {f.grp_egr, f.grp_ing};
    end
    key_d.key_vlan       = cfg_i.vlan   ? 12'd0 : f.vlan;
    key_d.key_mpls       = cfg_i.mpls   ? 20'd0 : f.mpls;
    key_d.key_addr_space = cfg_i.aspace ? 32'd0 : f.aspace;
    key_d.key_meta       = {!f.v4, f.ptype, (f.frag && !f.v4) ? 8'd0 : f.proto};
    key_d.swapped        = rev;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign key_o   = key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      key_q <= key_d;
    end
  end

  a_grp_unknown_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (key_q.key_groups[15:0] == fkn_pkg::GroupUnknown)
      |-> key_q.key_groups[31:16] == fkn_pkg::GroupUnknown)
    else $error("unknown group not applied to both sides");

  a_vlan_agn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && cfg_i.vlan |-> key_q.key_vlan == 12'd0)
    else $error("vlan tag kept while agnostic");

  a_mpls_agn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && cfg_i.mpls |-> key_q.key_mpls == 20'd0)
    else $error("mpls label kept while agnostic");

endmodule

>>> rtl/core/flow_key_normalizer.sv
// An accepted input transaction passes through three registered stages to its key:
// ICMP rewrite, address compare, ordering; one key per cycle while the output is not stalled.
// A stalled output holds each stage in place; ready runs back through all three.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears the agnostic
// registers to zero.
module flow_key_normalizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fkn_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fkn_pkg::CfgDataW-1:0]  cfg_data_i,
  fkn_flow_if.sink                      in_i,
  fkn_key_if.source                     out_o
);

  fkn_pkg::agn_cfg_t cfg_q;
  fkn_pkg::flow_t    flow_in;
  fkn_pkg::flow_t    s1_flow;
  fkn_pkg::cmp_t     s2_cmp;
  fkn_pkg::key_t     s3_key;
  logic              s1_valid, s1_ready, s2_valid, s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fkn_pkg::CFG_VLAN_AGN:   cfg_q.vlan   <= cfg_data_i[0];
        fkn_pkg::CFG_ASPACE_AGN: cfg_q.aspace <= cfg_data_i[0];
        fkn_pkg::CFG_MPLS_AGN:   cfg_q.mpls   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    flow_in.frag    = in_i.kind;
    flow_in.v4      = in_i.both_ipv4;
    flow_in.su      = in_i.src_addr_upper;
    flow_in.sl      = in_i.src_addr_lower;
    flow_in.du      = in_i.dst_addr_upper;
    flow_in.dl      = in_i.dst_addr_lower;
    flow_in.sp      = in_i.ports_or_id[15:0];
    flow_in.dp      = in_i.ports_or_id[31:16];
    flow_in.proto   = in_i.proto_and_type[7:0];
    flow_in.ptype   = in_i.proto_and_type[15:8];
    flow_in.vlan    = in_i.vlan_id;
    flow_in.mpls    = in_i.mpls_in;
    flow_in.aspace  = in_i.addr_space_in;
    flow_in.grp_ing = in_i.groups_in[15:0];
    flow_in.grp_egr = in_i.groups_in[31:16];
  end

  fkn_icmp u_icmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .flow_i  (flow_in),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .flow_o  (s1_flow)
  );

  fkn_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .flow_i  (s1_flow),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .cmp_o   (s2_cmp)
  );

  fkn_order u_order (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .cmp_i   (s2_cmp),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .key_o   (s3_key)
  );

  assign out_o.low_addr_upper  = s3_key.low_addr_upper;
  assign out_o.low_addr_lower  = s3_key.low_addr_lower;
  assign out_o.high_addr_upper = s3_key.high_addr_upper;
  assign out_o.high_addr_lower = s3_key.high_addr_lower;
  assign out_o.key_ports       = s3_key.key_ports;
  assign out_o.key_groups      = s3_key.key_groups;
  assign out_o.key_vlan        = s3_key.key_vlan;
  assign out_o.key_mpls        = s3_key.key_mpls;
  assign out_o.key_addr_space  = s3_key.key_addr_space;
  assign out_o.key_meta        = s3_key.key_meta;
  assign out_o.swapped         = s3_key.swapped;

endmodule
